// ----- hw/rtl/one_wire_bus_master_defines.svh -----
// Assertion macros for the one-wire bus master checker.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

// Condition must hold whenever out of reset.
`define OWM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define OWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/owm_pkg.sv -----
// Shared types and constants for the one-wire bus master.
// No dependencies.
package owm_pkg;

  localparam int COUNTER_BITS = 10;
  localparam int CNT_W        = COUNTER_BITS;
  localparam int CMP_W        = (COUNTER_BITS > 10) ? COUNTER_BITS : 10;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int WRITE_HOLD_TICKS = 60;

  // operation codes
  localparam logic [1:0] OP_RESET = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // register indexes
  localparam int PADDR_W = 5;
  localparam logic [2:0] REG_RESET_LOW    = 3'd0;
  localparam logic [2:0] REG_PRES_DELAY   = 3'd1;
  localparam logic [2:0] REG_PRES_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_RECOVERY     = 3'd3;
  localparam logic [2:0] REG_SLOT_LOW     = 3'd4;
  localparam logic [2:0] REG_SAMPLE_DELAY = 3'd5;
  localparam logic [2:0] REG_SLOT_REST    = 3'd6;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [9:0] presence_delay_ticks;
    logic [9:0] presence_timeout_ticks;
    logic [9:0] reset_recovery_ticks;
    logic [3:0] slot_low_ticks;
    logic [5:0] sample_delay_ticks;
    logic [6:0] slot_rest_ticks;
  } cfg_t;

  typedef struct packed {
    logic       tick;
    logic       line_level;
    logic       start_req;
    logic [1:0] func;
    logic [7:0] write_byte;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
  } res_t;

endpackage

// ----- hw/rtl/owm_if.sv -----
// Valid/ready channel interfaces for the one-wire bus master.
// Depends on owm_pkg.
interface owm_in_if import owm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       tick;
  logic       line_level;
  logic       start_req;
  logic [1:0] func;
  logic [7:0] write_byte;

  modport source (output valid, tick, line_level, start_req, func, write_byte,
                  input ready);
  modport sink   (input valid, tick, line_level, start_req, func, write_byte,
                  output ready);
endinterface

interface owm_out_if import owm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_byte;

  modport source (output valid, drive_low, busy_res, done_res, presence, read_byte,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, presence, read_byte,
                  output ready);
endinterface

// ----- hw/rtl/owm_cfg_regs.sv -----
// APB-style timing register file for the one-wire bus master.
// Depends on owm_pkg.
module owm_cfg_regs import owm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[PADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks        <= 10'd480;
      cfg_r.presence_delay_ticks   <= 10'd60;
      cfg_r.presence_timeout_ticks <= 10'd240;
      cfg_r.reset_recovery_ticks   <= 10'd480;
      cfg_r.slot_low_ticks         <= 4'd1;
      cfg_r.sample_delay_ticks     <= 6'd14;
      cfg_r.slot_rest_ticks        <= 7'd45;
    end else if (wr_en) begin
      case (idx)
        REG_RESET_LOW:    cfg_r.reset_low_ticks        <= pwdata[9:0];
        REG_PRES_DELAY:   cfg_r.presence_delay_ticks   <= pwdata[9:0];
        REG_PRES_TIMEOUT: cfg_r.presence_timeout_ticks <= pwdata[9:0];
        REG_RECOVERY:     cfg_r.reset_recovery_ticks   <= pwdata[9:0];
        REG_SLOT_LOW:     cfg_r.slot_low_ticks         <= pwdata[3:0];
        REG_SAMPLE_DELAY: cfg_r.sample_delay_ticks     <= pwdata[5:0];
        REG_SLOT_REST:    cfg_r.slot_rest_ticks        <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RESET_LOW:    prdata = {22'd0, cfg_r.reset_low_ticks};
      REG_PRES_DELAY:   prdata = {22'd0, cfg_r.presence_delay_ticks};
      REG_PRES_TIMEOUT: prdata = {22'd0, cfg_r.presence_timeout_ticks};
      REG_RECOVERY:     prdata = {22'd0, cfg_r.reset_recovery_ticks};
      REG_SLOT_LOW:     prdata = {28'd0, cfg_r.slot_low_ticks};
      REG_SAMPLE_DELAY: prdata = {26'd0, cfg_r.sample_delay_ticks};
      REG_SLOT_REST:    prdata = {25'd0, cfg_r.slot_rest_ticks};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ----- hw/rtl/owm_seq.sv -----
// Bus timing sequencer: phase state, tick counter, bit shifter.
// Depends on owm_pkg. Advances one step per accepted transaction.
module owm_seq import owm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_item_t item,
  input  cfg_t     cfg,
  output res_t     res
);

  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_RST_LOW     = 4'd1;
  localparam logic [3:0] PH_RST_WAIT    = 4'd2;
  localparam logic [3:0] PH_RST_DETECT  = 4'd3;
  localparam logic [3:0] PH_RST_RECOVER = 4'd4;
  localparam logic [3:0] PH_SLOT_LOW    = 4'd5;
  localparam logic [3:0] PH_WRITE_HOLD  = 4'd6;
  localparam logic [3:0] PH_READ_WAIT   = 4'd7;
  localparam logic [3:0] PH_READ_REST   = 4'd8;

  logic [3:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc, cnt_adv;
  logic [2:0]       bit_r, bit_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [1:0]       op_r, op_nxt;
  logic             pres_r, pres_nxt;
  logic [7:0]       rd_r, rd_nxt;
  logic [CMP_W-1:0] tgt;
  logic             hit;
  logic             done;

  // phase target
  always_comb begin
    case (phase_r)
      PH_RST_LOW:     tgt = CMP_W'(cfg.reset_low_ticks);
      PH_RST_WAIT:    tgt = CMP_W'(cfg.presence_delay_ticks);
      PH_RST_DETECT:  tgt = CMP_W'(cfg.presence_timeout_ticks);
      PH_RST_RECOVER: tgt = CMP_W'(cfg.reset_recovery_ticks);
      PH_SLOT_LOW:    tgt = CMP_W'(cfg.slot_low_ticks);
      PH_WRITE_HOLD:  tgt = CMP_W'(WRITE_HOLD_TICKS);
      PH_READ_WAIT:   tgt = CMP_W'(cfg.sample_delay_ticks);
      PH_READ_REST:   tgt = CMP_W'(cfg.slot_rest_ticks);
      default:        tgt = '0;
    endcase
  end

  // saturating tick counter; zero target ends on first tick
  assign cnt_inc = (cnt_r != CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
  assign hit     = item.tick && ((CMP_W'(cnt_inc) >= tgt) || (cnt_inc == CNT_MAX));
  assign cnt_adv = !item.tick ? cnt_r : (hit ? '0 : cnt_inc);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    op_nxt    = op_r;
    pres_nxt  = pres_r;
    rd_nxt    = rd_r;
    done      = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (item.start_req && (item.func == OP_RESET || item.func == OP_WRITE ||
                               item.func == OP_READ)) begin
          op_nxt  = item.func;
          bit_nxt = '0;
          cnt_nxt = '0;
          if (item.func == OP_RESET) begin
            phase_nxt = PH_RST_LOW;
          end else begin
            shift_nxt = (item.func == OP_WRITE) ? item.write_byte : 8'd0;
            phase_nxt = PH_SLOT_LOW;
          end
        end
      end
      PH_RST_LOW: begin
        cnt_nxt = cnt_adv;
        if (hit) phase_nxt = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        cnt_nxt = cnt_adv;
        if (hit) phase_nxt = PH_RST_DETECT;
      end
      PH_RST_DETECT: begin
        if (!item.line_level) begin
          pres_nxt  = 1'b1;
          cnt_nxt   = '0;
          phase_nxt = PH_RST_RECOVER;
        end else begin
          cnt_nxt = cnt_adv;
          if (hit) begin
            pres_nxt  = 1'b0;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        end
      end
      PH_RST_RECOVER: begin
        cnt_nxt = cnt_adv;
        if (hit) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
      end
      PH_SLOT_LOW: begin
        cnt_nxt = cnt_adv;
        if (hit) phase_nxt = (op_r == OP_WRITE) ? PH_WRITE_HOLD : PH_READ_WAIT;
      end
      PH_WRITE_HOLD: begin
        cnt_nxt = cnt_adv;
        if (hit) begin
          shift_nxt = {1'b0, shift_r[7:1]};
          if (bit_r == 3'd7) begin
            bit_nxt   = '0;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            phase_nxt = PH_SLOT_LOW;
          end
        end
      end
      PH_READ_WAIT: begin
        cnt_nxt = cnt_adv;
        if (hit) begin
          shift_nxt = {item.line_level, shift_r[7:1]};
          phase_nxt = PH_READ_REST;
        end
      end
      PH_READ_REST: begin
        cnt_nxt = cnt_adv;
        if (hit) begin
          if (bit_r == 3'd7) begin
            bit_nxt   = '0;
            rd_nxt    = shift_r;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            phase_nxt = PH_SLOT_LOW;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      op_r    <= OP_RESET;
      pres_r  <= 1'b0;
      rd_r    <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      op_r    <= op_nxt;
      pres_r  <= pres_nxt;
      rd_r    <= rd_nxt;
    end
  end

  // result reflects the state after this step
  always_comb begin
    if (phase_nxt == PH_RST_LOW || phase_nxt == PH_SLOT_LOW) begin
      res.drive_low = 1'b1;
    end else if (phase_nxt == PH_WRITE_HOLD) begin
      res.drive_low = ~shift_nxt[0];
    end else begin
      res.drive_low = 1'b0;
    end
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.presence  = pres_nxt;
    res.read_byte = rd_nxt;
  end

endmodule

// ----- hw/rtl/one_wire_bus_master.sv -----
// Latency: a result is valid the cycle after its input transaction is accepted.
// Throughput: one transaction per clock, unless a result waits undrained with out ready low.
// in ready stays high while the result register is empty or being drained.
// Reset (rst_n low, synchronous): sequencer idle, counters and bytes zero,
// result register empty, timing registers back to their default values.
module one_wire_bus_master import owm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  owm_in_if.sink             in_if,
  owm_out_if.source          out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t     cfg;
  in_item_t item;
  res_t     res_nxt;
  res_t     res_r;
  logic     out_valid_r;
  logic     in_accept;

  // Timing registers, APB-style write/read port.
  owm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pack the incoming transaction.
  assign item.tick       = in_if.tick;
  assign item.line_level = in_if.line_level;
  assign item.start_req  = in_if.start_req;
  assign item.func       = in_if.func;
  assign item.write_byte = in_if.write_byte;

  // Input side keeps flowing while the result register is free or emptying.
  assign in_if.ready = ~out_valid_r | out_if.ready;
  assign in_accept   = in_if.valid & in_if.ready;

  // Sequencer: state moves only on an accepted transaction.
  owm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_accept),
    .item  (item),
    .cfg   (cfg),
    .res   (res_nxt)
  );

  // Result register: one entry, separates the two handshakes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.drive_low = res_r.drive_low;
  assign out_if.busy_res  = res_r.busy_res;
  assign out_if.done_res  = res_r.done_res;
  assign out_if.presence  = res_r.presence;
  assign out_if.read_byte = res_r.read_byte;

endmodule

// ----- hw/rtl/owm_checker.sv -----
// Port-level checks for one_wire_bus_master, attached with bind.
// Depends on one_wire_bus_master_defines.svh.
`include "one_wire_bus_master_defines.svh"

module owm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       drive_low,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_byte
);

  // stalled result holds
  `OWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_byte) && $stable(busy_res), "stalled result changed")

  // no new transaction taken while a result waits undrained
  `OWM_ASSERT_ALWAYS(a_no_overrun, !(in_valid && in_ready && out_valid && !out_ready), "input taken over a stalled result")

  // finishing transaction leaves the master idle
  `OWM_ASSERT_ALWAYS(a_done_idle, !(out_valid && done_res && busy_res), "done while busy")

  // line only pulled low during an operation
  `OWM_ASSERT_ALWAYS(a_drive_busy, !(out_valid && drive_low && !busy_res), "drive low while idle")

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .drive_low (out_if.drive_low),
  .busy_res  (out_if.busy_res),
  .done_res  (out_if.done_res),
  .read_byte (out_if.read_byte)
);

// ----- dv/one_wire_bus_master_tb.sv -----
// Self-checking bench for the one-wire bus master: timed reset, write and read
// sequences under random handshake idling, checked per transaction.
// Depends on owm_pkg, owm_in_if/owm_out_if and the one_wire_bus_master RTL.
`timescale 1ns / 100ps

module one_wire_bus_master_tb;
  import owm_pkg::*;

  // func value with no operation behind it
  localparam logic [1:0] FUNC_NONE = 2'd3;
  // address slot past the last timing register
  localparam logic [2:0] REG_UNMAPPED = 3'd7;
  localparam int NUM_REGS = 7;
  // quiet cycles (no transaction, no register access) before giving up
  localparam int WATCHDOG_LIMIT = 2000;

  // sequencer phases as the bench tracks them
  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_DETECT, SEQ_RST_RECOVER,
    SEQ_SLOT_LOW, SEQ_WRITE_HOLD, SEQ_READ_WAIT, SEQ_READ_REST
  } seq_phase_e;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  owm_in_if  in_if ();
  owm_out_if out_if ();

  one_wire_bus_master dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bus items waiting to be driven, and bus status the block owes us.
  in_item_t bus_items[$];
  res_t     pending_status[$];
  int       mismatches = 0;

  // Shadow of the timing registers, masked to their widths.
  logic [9:0] timing [NUM_REGS];

  // Shadow sequencer state.
  seq_phase_e       seq_phase;
  logic [CNT_W-1:0] seq_ticks;
  logic [2:0]       seq_bit;
  logic [7:0]       seq_shift;
  logic [1:0]       seq_op;
  logic             seq_presence;
  logic [7:0]       seq_read_byte;

  // Sender burst/gap state and receiver stall pattern.
  int          burst_left;
  int          gap_left;
  logic [31:0] stall_pat;
  int          pat_age;
  int          quiet_cycles = 0;

  function automatic logic [31:0] field_mask(input logic [2:0] idx);
    case (idx)
      REG_SLOT_LOW:     return 32'h0F;
      REG_SAMPLE_DELAY: return 32'h3F;
      REG_SLOT_REST:    return 32'h7F;
      default:          return 32'h3FF;
    endcase
  endfunction

  // One tick of bus time toward a phase target. A zero target acts like one;
  // the counter sticks at its top value and that also ends the phase.
  function automatic bit tick_reached(input int unsigned target, input logic tick_in);
    if (!tick_in) return 1'b0;
    if (seq_ticks < CNT_MAX) seq_ticks++;
    if (int'(seq_ticks) >= target || seq_ticks == CNT_MAX) begin
      seq_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Closes a bit slot; true once all eight bits are out (or in).
  function automatic bit byte_finished();
    if (seq_bit == 3'd7) begin
      seq_bit = '0;
      return 1'b1;
    end
    seq_bit++;
    seq_phase = SEQ_SLOT_LOW;
    return 1'b0;
  endfunction

  // Advances the shadow sequencer by one bus item and returns the status the
  // block should report for it.
  function automatic res_t predict_bus_status(input in_item_t it);
    res_t r;
    r.done_res = 1'b0;
    case (seq_phase)
      SEQ_IDLE: begin
        // func 3 is no operation; anything else starts
        if (it.start_req && it.func != FUNC_NONE) begin
          seq_op    = it.func;
          seq_bit   = '0;
          seq_ticks = '0;
          if (it.func == OP_RESET) begin
            seq_phase = SEQ_RST_LOW;
          end else begin
            seq_shift = (it.func == OP_WRITE) ? it.write_byte : 8'h00;
            seq_phase = SEQ_SLOT_LOW;
          end
        end
      end
      SEQ_RST_LOW:
        if (tick_reached(timing[REG_RESET_LOW], it.tick)) seq_phase = SEQ_RST_WAIT;
      SEQ_RST_WAIT:
        if (tick_reached(timing[REG_PRES_DELAY], it.tick)) seq_phase = SEQ_RST_DETECT;
      SEQ_RST_DETECT: begin
        // line is looked at on every item, tick or not
        if (!it.line_level) begin
          seq_presence = 1'b1;
          seq_ticks    = '0;
          seq_phase    = SEQ_RST_RECOVER;
        end else if (tick_reached(timing[REG_PRES_TIMEOUT], it.tick)) begin
          // nobody answered: done at once, no recovery
          seq_presence = 1'b0;
          seq_phase    = SEQ_IDLE;
          r.done_res   = 1'b1;
        end
      end
      SEQ_RST_RECOVER: begin
        if (tick_reached(timing[REG_RECOVERY], it.tick)) begin
          seq_phase  = SEQ_IDLE;
          r.done_res = 1'b1;
        end
      end
      SEQ_SLOT_LOW: begin
        if (tick_reached(timing[REG_SLOT_LOW], it.tick))
          seq_phase = (seq_op == OP_WRITE) ? SEQ_WRITE_HOLD : SEQ_READ_WAIT;
      end
      SEQ_WRITE_HOLD: begin
        if (tick_reached(WRITE_HOLD_TICKS, it.tick)) begin
          seq_shift = seq_shift >> 1;
          if (byte_finished()) begin
            seq_phase  = SEQ_IDLE;
            r.done_res = 1'b1;
          end
        end
      end
      SEQ_READ_WAIT: begin
        // sample comes from the item that ends the delay; bits enter at the top
        if (tick_reached(timing[REG_SAMPLE_DELAY], it.tick)) begin
          seq_shift = {it.line_level, seq_shift[7:1]};
          seq_phase = SEQ_READ_REST;
        end
      end
      SEQ_READ_REST: begin
        if (tick_reached(timing[REG_SLOT_REST], it.tick)) begin
          if (byte_finished()) begin
            seq_read_byte = seq_shift;
            seq_phase     = SEQ_IDLE;
            r.done_res    = 1'b1;
          end
        end
      end
      default: seq_phase = SEQ_IDLE;
    endcase
    r.drive_low = (seq_phase == SEQ_RST_LOW) || (seq_phase == SEQ_SLOT_LOW) ||
                  (seq_phase == SEQ_WRITE_HOLD && !seq_shift[0]);
    r.busy_res  = (seq_phase != SEQ_IDLE);
    r.presence  = seq_presence;
    r.read_byte = seq_read_byte;
    return r;
  endfunction

  // Sender: pops pending items, bursts of random length with random gaps,
  // and once in a while a long burst with no gaps at all.
  always @(posedge clk) begin : sender
    in_item_t nxt;
    if (!rst_n) begin
      in_if.valid      <= 1'b0;
      in_if.tick       <= 1'b0;
      in_if.line_level <= 1'b1;
      in_if.start_req  <= 1'b0;
      in_if.func       <= OP_RESET;
      in_if.write_byte <= 8'h00;
      burst_left = 0;
      gap_left   = 0;
      seq_phase     = SEQ_IDLE;
      seq_ticks     = '0;
      seq_bit       = '0;
      seq_shift     = '0;
      seq_op        = OP_RESET;
      seq_presence  = 1'b0;
      seq_read_byte = '0;
      timing[REG_RESET_LOW]    = 10'd480;
      timing[REG_PRES_DELAY]   = 10'd60;
      timing[REG_PRES_TIMEOUT] = 10'd240;
      timing[REG_RECOVERY]     = 10'd480;
      timing[REG_SLOT_LOW]     = 10'd1;
      timing[REG_SAMPLE_DELAY] = 10'd14;
      timing[REG_SLOT_REST]    = 10'd45;
    end else begin
      if (in_if.valid && in_if.ready)
        pending_status.push_back(predict_bus_status(in_item_t'({in_if.tick,
          in_if.line_level, in_if.start_req, in_if.func, in_if.write_byte})));
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (bus_items.size() == 0) begin
          in_if.valid <= 1'b0;
        end else begin
          nxt = bus_items.pop_front();
          in_if.tick       <= nxt.tick;
          in_if.line_level <= nxt.line_level;
          in_if.start_req  <= nxt.start_req;
          in_if.func       <= nxt.func;
          in_if.write_byte <= nxt.write_byte;
          in_if.valid      <= 1'b1;
          if (burst_left == 0)
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // Receiver: ready follows a rotating stall pattern that is redrawn whenever
  // pat_age runs out (always ready, random, sparse or mostly ready).
  always @(posedge clk) begin : receiver
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_pat = '1;
      pat_age   = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = res_t'({out_if.drive_low, out_if.busy_res, out_if.done_res,
                      out_if.presence, out_if.read_byte});
        if (pending_status.size() == 0) begin
          mismatches++;
          $display("%0t: status transaction with none expected, got %p", $time, got);
        end else begin
          want = pending_status.pop_front();
          if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
              got.done_res !== want.done_res || got.presence !== want.presence ||
              got.read_byte !== want.read_byte) begin
            mismatches++;
            $display({"%0t: status mismatch (drive busy done presence byte) ",
                      "expected %b %b %b %b %02h, got %b %b %b %b %02h"},
                     $time, want.drive_low, want.busy_res, want.done_res, want.presence,
                     want.read_byte, got.drive_low, got.busy_res, got.done_res,
                     got.presence, got.read_byte);
          end
        end
      end
      pat_age++;
      if (pat_age >= 256) begin
        pat_age = 0;
        case ($urandom_range(0, 3))
          0:       stall_pat = '1;
          1:       stall_pat = $urandom | 32'h1;
          2:       stall_pat = ($urandom & $urandom) | 32'h1;
          default: stall_pat = ~($urandom & $urandom & $urandom) | 32'h1;
        endcase
      end
      out_if.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[31:1]};
    end
  end

  // Watchdog: counts cycles with no transaction on either side and no
  // register access.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("one_wire_bus_master test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Register access over APB
  // ---------------------------------------------------------------------

  // setup cycle, then access; the write lands on the access edge
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx != REG_UNMAPPED) timing[idx] = 10'(data & field_mask(idx));
  endtask

  // read back one register and compare with the shadow copy
  task automatic cfg_check(input logic [2:0] idx);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {22'd0, timing[idx]}) begin
      mismatches++;
      $display("%0t: register %0d read expected %0h, got %0h", $time, idx,
               {22'd0, timing[idx]}, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes all seven timing registers, then reads them back. With junk set,
  // bits above each field are filled with noise and the unmapped slot is hit.
  task automatic set_timing(input int unsigned rst_low, input int unsigned pres_delay,
                            input int unsigned pres_timeout, input int unsigned recovery,
                            input int unsigned slot_low, input int unsigned sample_delay,
                            input int unsigned slot_rest, input bit junk);
    logic [31:0] vals [NUM_REGS];
    logic [31:0] data;
    int i;
    vals[REG_RESET_LOW]    = rst_low;
    vals[REG_PRES_DELAY]   = pres_delay;
    vals[REG_PRES_TIMEOUT] = pres_timeout;
    vals[REG_RECOVERY]     = recovery;
    vals[REG_SLOT_LOW]     = slot_low;
    vals[REG_SAMPLE_DELAY] = sample_delay;
    vals[REG_SLOT_REST]    = slot_rest;
    for (i = 0; i < NUM_REGS; i++) begin
      data = vals[i];
      if (junk) data = data | ($urandom & ~field_mask(3'(i)));
      cfg_write(3'(i), data);
    end
    if (junk) cfg_write(REG_UNMAPPED, $urandom);
    for (i = 0; i < NUM_REGS; i++) cfg_check(3'(i));
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic queue_item(input logic tick_in, input logic line_in, input logic start_in,
                            input logic [1:0] func_in, input logic [7:0] byte_in);
    in_item_t it;
    it.tick       = tick_in;
    it.line_level = line_in;
    it.start_req  = start_in;
    it.func       = func_in;
    it.write_byte = byte_in;
    bus_items.push_back(it);
  endtask

  // n ticking items with no start; line pulled low low_pct percent of the time
  task automatic queue_ticks(input int n, input int low_pct);
    repeat (n)
      queue_item(1'b1, $urandom_range(0, 99) >= low_pct, 1'b0, 2'($urandom), 8'($urandom));
  endtask

  // Random traffic. Start requests come often, so a new operation usually
  // begins a few items after the last one ends; writes are kept rarer since
  // their 60-tick hold makes them long.
  task automatic queue_traffic(input int n, input int tick_pct, input int low_pct,
                               input int start_pct, input int write_pct);
    logic [1:0] f;
    logic [7:0] b;
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < write_pct) f = OP_WRITE;
      else if (r < write_pct + 6) f = FUNC_NONE;
      else f = $urandom_range(0, 1) ? OP_READ : OP_RESET;
      if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else b = 8'($urandom);
      queue_item($urandom_range(0, 99) < tick_pct, $urandom_range(0, 99) >= low_pct,
                 $urandom_range(0, 99) < start_pct, f, b);
    end
  endtask

  // wait until every item is driven and every status transaction is back
  task automatic drain_results();
    @(negedge clk);
    while (bus_items.size() != 0 || in_if.valid || pending_status.size() != 0)
      @(negedge clk);
  endtask

  // Before touching registers: let any operation in flight run out. The line
  // is held low so a presence wait ends right away.
  task automatic settle_sequencer();
    drain_results();
    while (seq_phase != SEQ_IDLE) begin
      queue_ticks(16, 100);
      drain_results();
    end
    repeat (2) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int b;
    logic [7:0] read_pattern;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_if.valid      = 1'b0;
    in_if.tick       = 1'b0;
    in_if.line_level = 1'b1;
    in_if.start_req  = 1'b0;
    in_if.func       = OP_RESET;
    in_if.write_byte = 8'h00;
    out_if.ready     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // register defaults after reset
    for (b = 0; b < NUM_REGS; b++) cfg_check(3'(b));

    // --- directed, every timing register set to one ---
    set_timing(1, 1, 1, 1, 1, 1, 1, 1'b0);
    // reset answered by a presence pulse on an item without a tick
    queue_item(1'b0, 1'b1, 1'b1, OP_RESET, 8'h00);
    queue_ticks(2, 0);
    queue_item(1'b0, 1'b0, 1'b0, OP_RESET, 8'h00);
    // start while busy is dropped; this tick also ends recovery
    queue_item(1'b1, 1'b1, 1'b1, OP_WRITE, 8'h00);
    // reset nobody answers: times out
    queue_item(1'b0, 1'b1, 1'b1, OP_RESET, 8'hFF);
    queue_ticks(3, 0);
    // func 3 does nothing
    queue_item(1'b1, 1'b1, 1'b1, FUNC_NONE, 8'hFF);
    // read byte 0x96: low slot, sample, rest per bit
    read_pattern = 8'h96;
    queue_item(1'b0, 1'b1, 1'b1, OP_READ, 8'h5A);
    for (b = 0; b < 8; b++) begin
      queue_item(1'b1, 1'b1, 1'b0, OP_RESET, 8'h00);
      queue_item(1'b1, read_pattern[b], 1'b0, OP_RESET, 8'h00);
      queue_item(1'b1, 1'b1, 1'b0, OP_RESET, 8'h00);
    end
    // write 0xFF: line released through every hold
    queue_item(1'b0, 1'b1, 1'b1, OP_WRITE, 8'hFF);
    queue_ticks(8 * (1 + WRITE_HOLD_TICKS), 0);
    settle_sequencer();

    // --- short timings, with a pause halfway until everything is back ---
    set_timing($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
               $urandom_range(1, 8), $urandom_range(1, 3), $urandom_range(1, 6),
               $urandom_range(1, 6), 1'b0);
    queue_traffic(80, 80, 30, 40, 0);
    drain_results();
    repeat ($urandom_range(3, 20)) @(negedge clk);
    queue_traffic(80, 80, 30, 40, 0);
    settle_sequencer();

    // --- zero in every register: each acts as a single tick ---
    set_timing(0, 0, 0, 0, 0, 0, 0, 1'b0);
    queue_traffic(120, 60, 40, 35, 0);
    settle_sequencer();

    // --- noise above each field, unmapped slot written ---
    set_timing($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 12),
               $urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(1, 5),
               $urandom_range(1, 5), 1'b1);
    queue_traffic(120, 75, 60, 30, 0);
    settle_sequencer();

    // --- every register at its maximum: written and read back ---
    set_timing(1023, 1023, 1023, 1023, 15, 63, 127, 1'b0);

    // --- mid-range timings ---
    set_timing($urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(1, 20),
               $urandom_range(1, 20), $urandom_range(1, 15), $urandom_range(1, 20),
               $urandom_range(1, 20), 1'b1);
    queue_traffic(120, 85, 45, 30, 3);

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("one_wire_bus_master test passed");
    end else begin
      $display("one_wire_bus_master test failed");
    end
    $finish;
  end

endmodule

// ----- one_wire_bus_master.f -----
+incdir+hw/rtl
hw/rtl/owm_pkg.sv
hw/rtl/owm_if.sv
hw/rtl/owm_cfg_regs.sv
hw/rtl/owm_seq.sv
hw/rtl/one_wire_bus_master.sv
hw/rtl/owm_checker.sv
dv/one_wire_bus_master_tb.sv
